>>> design/hot_page_counter_filter_core_macros.svh
// Assertion macros shared by the hot page counter filter modules
`ifndef HOT_PAGE_COUNTER_FILTER_CORE_MACROS_SVH
`define HOT_PAGE_COUNTER_FILTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HPCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HPCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/hpcf_pkg.sv
// Shared constants, types and helpers of the hot page counter filter
`timescale 1ns / 1ps

package hpcf_pkg;

    // page store size; a power of two, the page address wraps modulo this
    localparam int PAGE_COUNT = 65536;
    localparam int PAGE_W     = $clog2(PAGE_COUNT);
    localparam int ADDR_IN_W  = 16;
    localparam int IDX_EXT_W  = (PAGE_W > ADDR_IN_W) ? PAGE_W : ADDR_IN_W;

    localparam int DATA_W    = 32;
    localparam int CTR_W     = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE      = 2'd0,
        KIND_INVALIDATE = 2'd1,
        KIND_CHECK      = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PAGES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_START_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD    = 2'd3;

    localparam logic [DATA_W-1:0] RST_WINDOW_PAGES     = 32'd65536;
    localparam logic [DATA_W-1:0] RST_COLD_START_PAGES = 32'd65536;
    localparam logic [CTR_W-1:0]  RST_MAX_COUNT        = 2'd3;
    localparam logic [CTR_W-1:0]  RST_HOT_THRESHOLD    = 2'd3;

    typedef struct packed {
        logic clear;    // write zero at the sweep address
        logic accept;   // capture the incoming word
        logic update;   // read-modify-write and result
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

    function automatic logic [PAGE_W-1:0] page_index(input logic [ADDR_IN_W-1:0] addr);
        logic [IDX_EXT_W-1:0] ext;
        ext = IDX_EXT_W'(addr);
        return ext[PAGE_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        return (v == '1) ? v : v + DATA_W'(1);
    endfunction

endpackage

>>> design/hot_page_counter_filter_core.sv
// Top level of the hot page counter filter
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | start & !busy          | i_kind, i_page_addr, i_in_group_one,
//            |                        | i_segment_age, i_mapped_group_zero
//   result   | o_strobe (one cycle)   | o_is_hot, o_skipped_cold, o_window_expired,
//            |                        | o_total_checks, o_hot_checks
//   config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// For each word, the accept edge reads the page counter from the counter
// memory; the update state then writes it back (write and invalidate words
// only) and loads the result. busy is high in the update state that follows
// an accept; the strobe shows in the cycle after that state and can overlap the next accept.
// After reset the counter memory is swept to zero, one page a cycle, over all
// PAGE_COUNT (65536) pages with busy high; config writes are taken meanwhile.
// The receiver cannot stall; each result is valid for the strobe cycle only.
`timescale 1ns / 1ps

module hot_page_counter_filter_core
    import hpcf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ADDR_IN_W-1:0] i_page_addr,
    input  logic                 i_in_group_one,
    input  logic [DATA_W-1:0]    i_segment_age,
    input  logic                 i_mapped_group_zero,
    output logic                 o_strobe,
    output logic                 o_is_hot,
    output logic                 o_skipped_cold,
    output logic                 o_window_expired,
    output logic [DATA_W-1:0]    o_total_checks,
    output logic [DATA_W-1:0]    o_hot_checks
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    hpcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    hpcf_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (i_kind),
        .i_page_addr         (i_page_addr),
        .i_in_group_one      (i_in_group_one),
        .i_segment_age       (i_segment_age),
        .i_mapped_group_zero (i_mapped_group_zero),
        .o_strobe            (o_strobe),
        .o_is_hot            (o_is_hot),
        .o_skipped_cold      (o_skipped_cold),
        .o_window_expired    (o_window_expired),
        .o_total_checks      (o_total_checks),
        .o_hot_checks        (o_hot_checks)
    );

endmodule

>>> design/hpcf_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module hpcf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/hpcf_datapath.sv
// Datapath: counter memory, countdowns, check counters and result registers
`timescale 1ns / 1ps

module hpcf_datapath
    import hpcf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ADDR_IN_W-1:0] i_page_addr,
    input  logic                 i_in_group_one,
    input  logic [DATA_W-1:0]    i_segment_age,
    input  logic                 i_mapped_group_zero,
    output logic                 o_strobe,
    output logic                 o_is_hot,
    output logic                 o_skipped_cold,
    output logic                 o_window_expired,
    output logic [DATA_W-1:0]    o_total_checks,
    output logic [DATA_W-1:0]    o_hot_checks
);

    logic [DATA_W-1:0] r_window_pages, n_window_pages;
    logic [CTR_W-1:0]  r_max_count, n_max_count;
    logic [CTR_W-1:0]  r_hot_thr, n_hot_thr;
    logic [DATA_W-1:0] r_cold_left, n_cold_left;
    logic [DATA_W-1:0] r_window_left, n_window_left;
    logic [DATA_W-1:0] r_check_total, n_check_total;
    logic [DATA_W-1:0] r_check_hot, n_check_hot;
    logic [PAGE_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_strobe, n_strobe;
    logic              r_hot, n_hot;
    logic              r_skipped, n_skipped;
    logic              r_expired, n_expired;

    // captured word
    t_kind             r_kind;
    logic [PAGE_W-1:0] r_idx;
    logic              r_group_one;
    logic [DATA_W-1:0] r_age;
    logic              r_group_zero;

    logic [CTR_W-1:0]  ctr;
    logic [CTR_W-1:0]  ctr_new;
    logic              ram_we;
    logic [PAGE_W-1:0] ram_waddr;
    logic [CTR_W-1:0]  ram_wdata;

    hpcf_ram #(
        .WIDTH (CTR_W),
        .DEPTH (PAGE_COUNT)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (page_index(i_page_addr)),
        .o_rdata (ctr)
    );

    assign o_stat.clear_last = (r_clr_addr == PAGE_W'(PAGE_COUNT - 1));

    always_comb begin
        n_window_pages = r_window_pages;
        n_max_count    = r_max_count;
        n_hot_thr      = r_hot_thr;
        n_cold_left    = r_cold_left;
        n_window_left  = r_window_left;
        n_check_total  = r_check_total;
        n_check_hot    = r_check_hot;
        n_clr_addr     = r_clr_addr;
        n_strobe       = 1'b0;
        n_hot          = r_hot;
        n_skipped      = r_skipped;
        n_expired      = r_expired;
        ctr_new        = ctr;
        ram_we         = 1'b0;
        ram_waddr      = r_idx;
        ram_wdata      = ctr_new;

        if (i_cmd.clear) begin
            n_clr_addr = r_clr_addr + PAGE_W'(1);
            ram_we     = 1'b1;
            ram_waddr  = r_clr_addr;
            ram_wdata  = '0;
        end

        if (i_cmd.update) begin
            n_strobe  = 1'b1;
            n_hot     = 1'b0;
            n_skipped = 1'b0;
            unique case (r_kind)
                KIND_WRITE, KIND_INVALIDATE: begin
                    ram_we = 1'b1;
                    if (r_cold_left != '0) begin
                        n_cold_left = r_cold_left - DATA_W'(1);
                        n_skipped   = 1'b1;
                    end else if (r_kind == KIND_WRITE) begin
                        if (r_window_left != '0) begin
                            n_window_left = r_window_left - DATA_W'(1);
                        end
                        if (r_group_one) begin
                            if (r_age <= r_window_pages) begin
                                if (ctr < r_max_count) begin
                                    ctr_new = ctr + CTR_W'(1);
                                end
                            end else if (ctr != '0) begin
                                ctr_new = ctr - CTR_W'(1);
                            end
                        end
                    end else begin
                        // invalidate: group zero drops two steps, others one, floored at zero
                        if (r_group_zero && ctr >= CTR_W'(2)) begin
                            ctr_new = ctr - CTR_W'(2);
                        end else if (r_group_zero || ctr != '0) begin
                            ctr_new = (ctr != '0) ? ctr - CTR_W'(1) : ctr;
                            if (r_group_zero) begin
                                ctr_new = '0;
                            end
                        end
                    end
                    ram_wdata = ctr_new;
                end
                KIND_CHECK: begin
                    n_check_total = sat_inc(r_check_total);
                    if (ctr >= r_hot_thr) begin
                        n_check_hot = sat_inc(r_check_hot);
                        n_hot       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_expired = (n_window_left == '0);
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_PAGES: begin
                    n_window_pages = i_cfg_data;
                    n_window_left  = i_cfg_data;
                end
                REG_COLD_START_PAGES: begin
                    n_cold_left = i_cfg_data;
                end
                REG_MAX_COUNT:     n_max_count = i_cfg_data[CTR_W-1:0];
                REG_HOT_THRESHOLD: n_hot_thr   = i_cfg_data[CTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_pages <= RST_WINDOW_PAGES;
            r_max_count    <= RST_MAX_COUNT;
            r_hot_thr      <= RST_HOT_THRESHOLD;
            r_cold_left    <= RST_COLD_START_PAGES;
            r_window_left  <= RST_WINDOW_PAGES;
            r_check_total  <= '0;
            r_check_hot    <= '0;
            r_clr_addr     <= '0;
            r_strobe       <= 1'b0;
            r_hot          <= 1'b0;
            r_skipped      <= 1'b0;
            r_expired      <= 1'b0;
        end else begin
            r_window_pages <= n_window_pages;
            r_max_count    <= n_max_count;
            r_hot_thr      <= n_hot_thr;
            r_cold_left    <= n_cold_left;
            r_window_left  <= n_window_left;
            r_check_total  <= n_check_total;
            r_check_hot    <= n_check_hot;
            r_clr_addr     <= n_clr_addr;
            r_strobe       <= n_strobe;
            r_hot          <= n_hot;
            r_skipped      <= n_skipped;
            r_expired      <= n_expired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind       <= t_kind'(i_kind);
            r_idx        <= page_index(i_page_addr);
            r_group_one  <= i_in_group_one;
            r_age        <= i_segment_age;
            r_group_zero <= i_mapped_group_zero;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_is_hot         = r_hot;
    assign o_skipped_cold   = r_skipped;
    assign o_window_expired = r_expired;
    assign o_total_checks   = r_check_total;
    assign o_hot_checks     = r_check_hot;

`include "hot_page_counter_filter_core_macros.svh"

    `HPCF_ASSERT_NEXT(a_strobe_single, r_strobe, !r_strobe,
        "result strobe held for more than one cycle")
    `HPCF_ASSERT_NOW(a_hot_le_total, 1'b1, r_check_hot <= r_check_total,
        "hot check count exceeds total check count")
    `HPCF_ASSERT_NOW(a_skip_counts_down, r_strobe && r_skipped,
        r_cold_left == $past(r_cold_left) - 32'd1,
        "skipped update did not count the cold-start countdown down")

endmodule

>>> design/hpcf_ctrl.sv
// Controller: clearing sweep, word acceptance and update sequencing
`timescale 1ns / 1ps

module hpcf_ctrl
    import hpcf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.clear  = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.update = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

`include "hot_page_counter_filter_core_macros.svh"

    `HPCF_ASSERT_NEXT(a_accept_to_update, o_cmd.accept, r_state == ST_UPDATE,
        "accepted word not followed by its update cycle")
    `HPCF_ASSERT_NEXT(a_update_once, r_state == ST_UPDATE, r_state == ST_IDLE,
        "update cycle did not return to idle")
    `HPCF_ASSERT_NEXT(a_no_reclear, r_state == ST_IDLE, r_state != ST_CLEAR,
        "clearing sweep restarted outside reset")

endmodule
